// ===== rtl/tty_pkg.sv =====
// Shared types, codes and character constants for the tty output cooker.
`timescale 1ns / 1ps

package tty_pkg;

    // Input operation codes
    localparam logic [1:0] OP_PRINT = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    localparam logic [7:0] RST_WIDTH  = 8'd80;
    localparam logic [7:0] RST_HEIGHT = 8'd25;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int TAB_STOP = 8;

    // What one item emits
    typedef enum logic [2:0] {
        BK_EMPTY,
        BK_CHAR,
        BK_NL,
        BK_CR,
        BK_BS,
        BK_TAB,
        BK_CLEAR
    } t_kind;

    // One item's worth of output: byte pattern, result count (1..8), final cursor
    typedef struct packed {
        t_kind      kind;
        logic [7:0] chr;
        logic [3:0] count;
        logic [7:0] column;
        logic [7:0] row;
    } t_burst;

endpackage

// ===== rtl/tty_cursor.sv =====
// Window size registers, cursor state and per-item cursor update.
`timescale 1ns / 1ps

module tty_cursor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_write,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_accept,
    input  logic [1:0]          i_operation,
    input  logic [7:0]          i_char_code,
    input  logic [7:0]          i_cursor_col,
    input  logic [7:0]          i_cursor_row,
    output tty_pkg::t_burst     o_burst
);
    import tty_pkg::*;

    logic [7:0] r_width, r_height, r_col, r_row;
    logic [7:0] n_col, n_row;
    logic [7:0] eff_w, eff_h, w_m1, h_m1;
    logic [8:0] row_inc, col_inc, tab_stop, tab_n;
    logic [7:0] nl_row;
    t_burst     burst;

    assign eff_w = (r_width  == 8'd0) ? 8'd1 : r_width;
    assign eff_h = (r_height == 8'd0) ? 8'd1 : r_height;
    assign w_m1  = eff_w - 8'd1;
    assign h_m1  = eff_h - 8'd1;

    assign row_inc = {1'b0, r_row} + 9'd1;
    assign nl_row  = (row_inc >= {1'b0, eff_h}) ? h_m1 : row_inc[7:0];
    assign col_inc = {1'b0, r_col} + 9'd1;

    always_comb begin
        tab_stop = ({1'b0, r_col} + 9'(TAB_STOP)) & ~9'(TAB_STOP - 1);
        if (tab_stop >= {1'b0, eff_w}) begin
            tab_stop = {1'b0, w_m1};
        end
        tab_n = (tab_stop > {1'b0, r_col}) ? (tab_stop - {1'b0, r_col}) : 9'd0;
    end

    always_comb begin
        burst.kind  = BK_EMPTY;
        burst.chr   = i_char_code;
        burst.count = 4'd1;
        n_col       = r_col;
        n_row       = r_row;
        unique case (i_operation)
            OP_PRINT: begin
                priority if (i_char_code == CH_LF) begin
                    burst.kind  = BK_NL;
                    burst.count = 4'd2;
                    n_col       = 8'd0;
                    n_row       = nl_row;
                end else if (i_char_code == CH_CR) begin
                    burst.kind = BK_CR;
                    n_col      = 8'd0;
                end else if (i_char_code == CH_BS) begin
                    if (r_col != 8'd0) begin
                        burst.kind  = BK_BS;
                        burst.count = 4'd3;
                        n_col       = r_col - 8'd1;
                    end
                end else if (i_char_code == CH_TAB) begin
                    // a tab already at its stop emits nothing
                    if (tab_n != 9'd0) begin
                        burst.kind  = BK_TAB;
                        burst.count = tab_n[3:0];
                        n_col       = r_col + tab_n[7:0];
                    end
                end else begin
                    burst.kind = BK_CHAR;
                    if (col_inc >= {1'b0, eff_w}) begin
                        n_col = 8'd0;
                        n_row = nl_row;
                    end else begin
                        n_col = col_inc[7:0];
                    end
                end
            end
            OP_SET: begin
                n_col = (i_cursor_col >= eff_w) ? w_m1 : i_cursor_col;
                n_row = (i_cursor_row >= eff_h) ? h_m1 : i_cursor_row;
            end
            OP_CLEAR: begin
                burst.kind  = BK_CLEAR;
                burst.count = 4'd7;
                n_col       = 8'd0;
                n_row       = 8'd0;
            end
            default: begin
            end
        endcase
        burst.column = n_col;
        burst.row    = n_row;
    end

    assign o_burst = burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_col    <= 8'd0;
            r_row    <= 8'd0;
        end else if (i_cfg_write) begin
            if (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT) begin
                if (i_cfg_index == REG_WIDTH) begin
                    r_width <= i_cfg_data;
                end else begin
                    r_height <= i_cfg_data;
                end
                r_col <= 8'd0;
                r_row <= 8'd0;
            end
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== rtl/tty_emit.sv =====
// Burst queue and serializer: turns one burst into its result transactions.
`timescale 1ns / 1ps

module tty_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tty_pkg::t_burst i_burst,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_tx_byte,
    output logic            o_byte_valid,
    output logic            o_last,
    output logic [7:0]      o_column,
    output logic [7:0]      o_row
);
    import tty_pkg::*;

    t_burst     r_cur, r_skid;
    logic       r_cur_vld, r_skid_vld;
    logic [2:0] r_idx;
    logic       take, pop, pop_last, cur_free, is_last;

    function automatic logic [7:0] burst_byte(input t_burst b, input logic [2:0] k);
        logic [7:0] v;
        v = 8'd0;
        unique case (b.kind)
            BK_CHAR: v = b.chr;
            BK_NL:   v = (k == 3'd0) ? CH_CR : CH_LF;
            BK_CR:   v = CH_CR;
            BK_BS:   v = (k == 3'd1) ? CH_SPACE : CH_BS;
            BK_TAB:  v = CH_SPACE;
            BK_CLEAR: begin
                // ESC [ 2 J ESC [ H
                unique case (k)
                    3'd0, 3'd4: v = CH_ESC;
                    3'd1, 3'd5: v = 8'h5B;
                    3'd2:       v = 8'h32;
                    3'd3:       v = 8'h4A;
                    default:    v = 8'h48;
                endcase
            end
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    assign is_last  = ({1'b0, r_idx} == (r_cur.count - 4'd1));
    assign o_ready  = !r_skid_vld;
    assign take     = i_valid && o_ready;
    assign pop      = r_cur_vld && i_ready;
    assign pop_last = pop && is_last;
    assign cur_free = !r_cur_vld || pop_last;

    assign o_valid      = r_cur_vld;
    assign o_tx_byte    = burst_byte(r_cur, r_idx);
    assign o_byte_valid = (r_cur.kind != BK_EMPTY);
    assign o_last       = is_last;
    assign o_column     = r_cur.column;
    assign o_row        = r_cur.row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
            r_idx      <= 3'd0;
        end else if (cur_free) begin
            r_idx <= 3'd0;
            if (r_skid_vld) begin
                r_cur      <= r_skid;
                r_cur_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_cur_vld <= take;
                if (take) begin
                    r_cur <= i_burst;
                end
            end
        end else begin
            if (pop) begin
                r_idx <= r_idx + 3'd1;
            end
            if (take) begin
                r_skid     <= i_burst;
                r_skid_vld <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/tty_output_cooker.sv =====
// Top level of the tty output cooker: cursor tracking console byte stream.
`timescale 1ns / 1ps

// Each input transaction prints a character, sets the cursor or clears the
// screen, and yields one to eight result transactions carrying the serial
// bytes (newline as CR LF, backspace as BS SP BS, tab as spaces to the next
// stop of 8, clear as ESC[2J ESC[H); an item that sends nothing yields one
// result with o_byte_valid low. Every result of an item shows the cursor
// after that item and o_last marks its final result. The cursor is updated
// in the cycle an item is taken, so items can be taken every cycle; results
// leave at one per cycle while i_out_ready is high, so an item of n bytes holds
// the output for n results and input is stalled once a second item queues behind it. Writing
// either window size register homes the cursor; write configuration only
// while no results are pending.
module tty_output_cooker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_cursor_col,
    input  logic [7:0] i_cursor_row,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_tx_byte,
    output logic       o_byte_valid,
    output logic       o_last,
    output logic [7:0] o_column,
    output logic [7:0] o_row
);
    import tty_pkg::*;

    t_burst burst;
    logic   in_ready;
    logic   accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = in_ready;
    assign accept      = i_in_valid && in_ready;

    tty_cursor u_cursor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_write  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_operation  (i_operation),
        .i_char_code  (i_char_code),
        .i_cursor_col (i_cursor_col),
        .i_cursor_row (i_cursor_row),
        .o_burst      (burst)
    );

    tty_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (in_ready),
        .i_burst      (burst),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_tx_byte    (o_tx_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_column     (o_column),
        .o_row        (o_row)
    );

endmodule

// ===== rtl/tty_checker.sv =====
// Port level checks for the tty output cooker, bound to the top level.
`timescale 1ns / 1ps

module tty_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_tx_byte,
    input logic       o_byte_valid,
    input logic       o_last,
    input logic [7:0] o_column,
    input logic [7:0] o_row
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_tx_byte)
            && $stable(o_last) && $stable(o_column) && $stable(o_row))
        else $error("stalled result changed");

    // an empty result is always the only one of its item
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_last)
        else $error("empty result not marked last");

    // results of one item follow at once and share the final cursor
    a_burst_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid && o_byte_valid
            && $stable(o_column) && $stable(o_row))
        else $error("cursor changed inside one item");

    // input stalls only behind pending output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending output");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind tty_output_cooker tty_checker u_tty_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_tx_byte    (o_tx_byte),
    .o_byte_valid (o_byte_valid),
    .o_last       (o_last),
    .o_column     (o_column),
    .o_row        (o_row)
);

// ===== tb/tty_cursor_checker.sv =====
// Cursor and byte stream predictor with result comparison for the tty output cooker.
`timescale 1ns / 1ps

module tty_cursor_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_cursor_col,
    input  logic [7:0] i_cursor_row,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_tx_byte,
    input  logic       i_byte_valid,
    input  logic       i_last,
    input  logic [7:0] i_column,
    input  logic [7:0] i_row,
    output int         o_errors,
    output int         o_pending
);
    import tty_pkg::*;

    // ESC [ 2 J ESC [ H, first byte in the top lane
    localparam logic [55:0] CLEAR_SEQ = {CH_ESC, 8'h5B, 8'h32, 8'h4A, CH_ESC, 8'h5B, 8'h48};

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       byte_valid;
        logic       last;
        logic [7:0] column;
        logic [7:0] row;
    } t_tty_result;

    t_tty_result expected_q[$];
    t_tty_result want_r;
    logic [7:0]  win_width;
    logic [7:0]  win_height;
    logic [7:0]  cursor_col;
    logic [7:0]  cursor_row;
    int          mismatch_count = 0;

    assign o_errors = mismatch_count;

    function automatic int unsigned size_or_one(input logic [7:0] v);
        return (v == 8'd0) ? 1 : 32'(v);
    endfunction

    // row saturates at the bottom, no scrolling
    function automatic logic [7:0] row_below(input logic [7:0] row_now, input int unsigned h);
        int unsigned nxt;
        nxt = 32'(row_now) + 1;
        return 8'((nxt >= h) ? h - 1 : nxt);
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        $display("%0t: %s mismatch: got %h, expected %h", $time, field, got, want);
    endtask

    // Cursor update and serial bytes for one accepted item
    task automatic cook_item(input logic [1:0] op, input logic [7:0] chr,
                             input logic [7:0] req_col, input logic [7:0] req_row);
        logic [7:0]  seq [8];
        int          n;
        int          k;
        int unsigned w;
        int unsigned h;
        int unsigned stop;
        int unsigned col;
        t_tty_result r;
        n = 0;
        w = size_or_one(win_width);
        h = size_or_one(win_height);
        case (op)
            OP_PRINT: begin
                case (chr)
                    CH_LF: begin
                        seq[0] = CH_CR;
                        seq[1] = CH_LF;
                        n = 2;
                        cursor_col = 8'd0;
                        cursor_row = row_below(cursor_row, h);
                    end
                    CH_CR: begin
                        seq[0] = CH_CR;
                        n = 1;
                        cursor_col = 8'd0;
                    end
                    CH_BS: begin
                        if (cursor_col != 8'd0) begin
                            cursor_col = cursor_col - 8'd1;
                            seq[0] = CH_BS;
                            seq[1] = CH_SPACE;
                            seq[2] = CH_BS;
                            n = 3;
                        end
                    end
                    CH_TAB: begin
                        stop = (32'(cursor_col) + TAB_STOP) / TAB_STOP * TAB_STOP;
                        if (stop >= w)
                            stop = w - 1;
                        col = 32'(cursor_col);
                        while (col < stop && n < 8) begin
                            seq[n] = CH_SPACE;
                            n++;
                            col++;
                        end
                        cursor_col = 8'(col);
                    end
                    default: begin
                        seq[0] = chr;
                        n = 1;
                        col = 32'(cursor_col) + 1;
                        if (col >= w) begin
                            col = 0;
                            cursor_row = row_below(cursor_row, h);
                        end
                        cursor_col = 8'(col);
                    end
                endcase
            end
            OP_SET: begin
                cursor_col = 8'((32'(req_col) >= w) ? w - 1 : 32'(req_col));
                cursor_row = 8'((32'(req_row) >= h) ? h - 1 : 32'(req_row));
            end
            OP_CLEAR: begin
                for (k = 0; k < 7; k++)
                    seq[k] = CLEAR_SEQ[8 * (6 - k) +: 8];
                n = 7;
                cursor_col = 8'd0;
                cursor_row = 8'd0;
            end
            default: ;
        endcase
        if (n == 0) begin
            r = '{tx_byte: 8'd0, byte_valid: 1'b0, last: 1'b1,
                  column: cursor_col, row: cursor_row};
            expected_q.push_back(r);
        end else begin
            for (k = 0; k < n; k++) begin
                r = '{tx_byte: seq[k], byte_valid: 1'b1, last: (k == n - 1),
                      column: cursor_col, row: cursor_row};
                expected_q.push_back(r);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_width = RST_WIDTH;
            win_height = RST_HEIGHT;
            cursor_col = 8'd0;
            cursor_row = 8'd0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WIDTH: begin
                        win_width = i_cfg_data;
                        cursor_col = 8'd0;
                        cursor_row = 8'd0;
                    end
                    REG_HEIGHT: begin
                        win_height = i_cfg_data;
                        cursor_col = 8'd0;
                        cursor_row = 8'd0;
                    end
                    default: ;
                endcase
            end
            // predict first so a same-cycle result still finds its expectation
            if (i_in_valid && i_in_ready)
                cook_item(i_operation, i_char_code, i_cursor_col, i_cursor_row);
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result, tx_byte", i_tx_byte, 8'd0);
                end else begin
                    want_r = expected_q.pop_front();
                    if (i_tx_byte !== want_r.tx_byte)
                        report_mismatch("tx_byte", i_tx_byte, want_r.tx_byte);
                    if (i_byte_valid !== want_r.byte_valid)
                        report_mismatch("byte_valid", {7'd0, i_byte_valid},
                                        {7'd0, want_r.byte_valid});
                    if (i_last !== want_r.last)
                        report_mismatch("last", {7'd0, i_last}, {7'd0, want_r.last});
                    if (i_column !== want_r.column)
                        report_mismatch("column", i_column, want_r.column);
                    if (i_row !== want_r.row)
                        report_mismatch("row", i_row, want_r.row);
                end
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Stimulus, flow control and verdict for the tty output cooker.
`timescale 1ns / 1ps

module testbench;
    import tty_pkg::*;

    localparam logic [1:0] OP_NONE    = 2'd3;  // unused operation: cursor unchanged, one empty result
    localparam logic [1:0] REG_SPARE  = 2'd3;  // no register behind this index
    localparam int         IDLE_LIMIT = 2000;
    localparam int         NUM_PHASES = 8;
    localparam int         PHASE_ITEMS = 41;

    typedef enum {RX_OPEN, RX_COIN, RX_QUARTER, RX_SPARSE, RX_BURSTY} t_rx_mode;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [1:0] i_operation;
    logic [7:0] i_char_code;
    logic [7:0] i_cursor_col;
    logic [7:0] i_cursor_row;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_tx_byte;
    logic       o_byte_valid;
    logic       o_last;
    logic [7:0] o_column;
    logic [7:0] o_row;

    int         chk_errors;
    int         chk_pending;
    int         burst_left = 0;
    int         idle_cycles = 0;
    logic [7:0] win_w = RST_WIDTH;
    logic [7:0] win_h = RST_HEIGHT;
    t_rx_mode   rx_mode = RX_OPEN;
    int         rx_left = 0;
    int         rx_tick = 0;
    logic       any_xfer;

    logic [7:0] phase_w [NUM_PHASES] = '{8'd8, 8'd1, 8'd255, 8'd0, 8'd17, 8'd255, 8'd1, 8'd0};
    logic [7:0] phase_h [NUM_PHASES] = '{8'd3, 8'd1, 8'd255, 8'd0, 8'd4, 8'd1, 8'd255, 8'd0};

    always #5 i_clk = ~i_clk;

    tty_output_cooker uut (.*);

    tty_cursor_checker tty_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_char_code  (i_char_code),
        .i_cursor_col (i_cursor_col),
        .i_cursor_row (i_cursor_row),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_tx_byte    (o_tx_byte),
        .i_byte_valid (o_byte_valid),
        .i_last       (o_last),
        .i_column     (o_column),
        .i_row        (o_row),
        .o_errors     (chk_errors),
        .o_pending    (chk_pending)
    );

    // Output side: a randomly chosen stall pattern, picked anew when its run ends
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 4));
            rx_left = $urandom_range(20, 150);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:    i_out_ready <= 1'b1;
            RX_COIN:    i_out_ready <= ($urandom_range(0, 1) == 0);
            RX_QUARTER: i_out_ready <= (rx_tick % 4 == 0);
            RX_SPARSE:  i_out_ready <= ($urandom_range(0, 3) == 0);
            default:    i_out_ready <= (rx_tick % 16 < 10);
        endcase
    end

    assign any_xfer = (i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
                      (o_out_valid && i_out_ready);

    always @(posedge i_clk) begin
        if (!i_rst_n || any_xfer) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // One input transaction; idle gaps are placed between bursts
    task automatic send_item(input logic [1:0] op, input logic [7:0] chr,
                             input logic [7:0] col, input logic [7:0] row);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_char_code <= chr;
        i_cursor_col <= col;
        i_cursor_row <= row;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // Both size registers, optionally followed by a write to the spare index
    task automatic write_window(input logic [7:0] w, input logic [7:0] h, input bit poke);
        logic [1:0] idx [3];
        logic [7:0] val [3];
        int         n;
        int         k;
        idx[0] = REG_WIDTH;
        val[0] = w;
        idx[1] = REG_HEIGHT;
        val[1] = h;
        idx[2] = REG_SPARE;
        val[2] = 8'($urandom_range(0, 255));
        n = poke ? 3 : 2;
        for (k = 0; k < n; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        win_w = w;
        win_h = h;
    endtask

    // Random character bytes, weighted toward control characters and cursor moves
    task automatic random_item();
        int unsigned pick;
        int unsigned ew;
        int unsigned eh;
        logic [1:0]  op;
        logic [7:0]  chr;
        logic [7:0]  col;
        logic [7:0]  row;
        pick = $urandom_range(0, 99);
        chr = 8'($urandom_range(0, 255));
        col = 8'($urandom_range(0, 255));
        row = 8'($urandom_range(0, 255));
        ew = (win_w == 8'd0) ? 1 : 32'(win_w);
        eh = (win_h == 8'd0) ? 1 : 32'(win_h);
        op = OP_PRINT;
        if (pick >= 50 && pick < 75) begin
            case ($urandom_range(0, 3))
                0:       chr = CH_LF;
                1:       chr = CH_CR;
                2:       chr = CH_BS;
                default: chr = CH_TAB;
            endcase
        end else if (pick >= 75 && pick < 90) begin
            op = OP_SET;
            // half the time stay within the window or one past its right and bottom edges
            if ($urandom_range(0, 1) == 0) begin
                col = 8'($urandom_range(0, ew));
                row = 8'($urandom_range(0, eh));
            end
        end else if (pick >= 90 && pick < 97) begin
            op = OP_CLEAR;
        end else if (pick >= 97) begin
            op = OP_NONE;
        end
        send_item(op, chr, col, row);
    endtask

    initial begin
        int p;
        int k;
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_WIDTH;
        i_cfg_data <= 8'd0;
        i_in_valid <= 1'b0;
        i_operation <= OP_PRINT;
        i_char_code <= 8'd0;
        i_cursor_col <= 8'd0;
        i_cursor_row <= 8'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 80 x 25 after reset
        send_item(OP_PRINT, 8'h41, 8'd0, 8'd0);
        send_item(OP_PRINT, 8'h00, 8'd0, 8'd0);
        send_item(OP_PRINT, 8'hFF, 8'd0, 8'd0);
        send_item(OP_PRINT, CH_TAB, 8'd0, 8'd0);     // col 3 -> 8
        send_item(OP_PRINT, CH_TAB, 8'd0, 8'd0);     // full 8 spaces
        send_item(OP_PRINT, CH_BS, 8'd0, 8'd0);
        send_item(OP_PRINT, CH_CR, 8'd0, 8'd0);
        send_item(OP_PRINT, CH_BS, 8'd0, 8'd0);      // at column zero: nothing sent
        send_item(OP_PRINT, CH_LF, 8'd0, 8'd0);
        send_item(OP_SET, 8'd0, 8'd255, 8'd255);     // clamps to the corner
        send_item(OP_PRINT, 8'h7A, 8'd0, 8'd0);      // wraps, row saturates
        send_item(OP_PRINT, CH_LF, 8'd0, 8'd0);      // bottom row saturates
        send_item(OP_SET, 8'd0, 8'd79, 8'd3);
        send_item(OP_PRINT, CH_TAB, 8'd0, 8'd0);     // tab stop clamped to the cursor column: nothing sent
        send_item(OP_SET, 8'd0, 8'd75, 8'd3);
        send_item(OP_PRINT, CH_TAB, 8'd0, 8'd0);     // clamped to last column
        send_item(OP_PRINT, 8'h7F, 8'd0, 8'd0);      // last column wraps
        send_item(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_NONE, 8'hA5, 8'h5A, 8'hC3);
        send_item(OP_SET, 8'd0, 8'd200, 8'd10);
        send_item(OP_SET, 8'd0, 8'd0, 8'd0);
        send_item(OP_PRINT, CH_LF, 8'd0, 8'd0);
        for (k = 0; k < PHASE_ITEMS; k++)
            random_item();

        for (p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            if (p == NUM_PHASES - 1)
                write_window(8'($urandom_range(2, 254)), 8'($urandom_range(2, 254)), 1'b0);
            else
                write_window(phase_w[p], phase_h[p], (phase_w[p] == 8'd0));
            for (k = 0; k < PHASE_ITEMS; k++)
                random_item();
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (chk_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tty_pkg.sv
rtl/tty_cursor.sv
rtl/tty_emit.sv
rtl/tty_output_cooker.sv
rtl/tty_checker.sv
tb/tty_cursor_checker.sv
tb/testbench.sv
